### sv/hms_pkg.sv
// ============================================================================
// hms_pkg
// Shared types and constants of the hours/minutes/seconds countdown timer.
// ============================================================================
package hms_pkg;

   // Millisecond ticks per counted second (2 to 2047).
   localparam int unsigned TicksPerSecond = 1000;
   localparam int unsigned PHASE_W        = 11;
   localparam logic [PHASE_W:0] TICKS_PER_SECOND = (PHASE_W + 1)'(TicksPerSecond);

   // Request kinds carried on the input channel's tuser.
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_BUTTON = 2'd1;
   localparam logic [1:0] REQ_RESET  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PRESET_HOURS   = 2'd0;
   localparam logic [1:0] CSR_PRESET_MINUTES = 2'd1;
   localparam logic [1:0] CSR_PRESET_SECONDS = 2'd2;
   localparam logic [1:0] CSR_FINISH_VOICE   = 2'd3;

   // Announcement codes; a final-ten-seconds code is the seconds plus one.
   localparam logic [3:0] ANN_ONE_MINUTE     = 4'd0;
   localparam logic [3:0] ANN_THIRTY_SECONDS = 4'd1;
   localparam logic [3:0] ANN_SECONDS_OFFSET = 4'd1;

   localparam logic [5:0] LAST_MINUTE_SECOND = 6'd59;
   localparam logic [5:0] THIRTY_SECONDS     = 6'd30;
   localparam logic [5:0] TEN_SECONDS        = 6'd10;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_COUNTING = 2'd1,
      MODE_PAUSED   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0] finish_voice;
      logic [5:0] preset_seconds;
      logic [5:0] preset_minutes;
      logic [3:0] preset_hours;
   } cfg_type;

   // Packed so that the first field sits in the highest bits.
   typedef struct packed {
      logic [2:0] finish_sound;
      logic       finished;
      logic [3:0] announce_code;
      logic       announce_valid;
      logic [5:0] seconds_left;
      logic [5:0] minutes_left;
      logic [3:0] hours_left;
      logic [1:0] mode;
   } result_type;

endpackage

### sv/hms_csr.sv
// ============================================================================
// hms_csr
// Configuration registers of the countdown timer: presets and finish voice.
// ============================================================================
module hms_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [5:0]       csr_data,
   output hms_pkg::cfg_type cfg
);
   import hms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PRESET_HOURS:   cfg_in.preset_hours   = csr_data[3:0];
            CSR_PRESET_MINUTES: cfg_in.preset_minutes = csr_data;
            CSR_PRESET_SECONDS: cfg_in.preset_seconds = csr_data;
            CSR_FINISH_VOICE:   cfg_in.finish_voice   = csr_data[2:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

### sv/hms_core.sv
// ============================================================================
// hms_core
// Timer state and the single-pass update for one tick, button or reset word.
// ============================================================================
module hms_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [1:0]          req_type,
   input  logic                voice_busy,
   input  hms_pkg::cfg_type    cfg,
   output hms_pkg::result_type rslt
);
   import hms_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [3:0]         hours_ff, hours_in;
   logic [5:0]         minutes_ff, minutes_in;
   logic [5:0]         seconds_ff, seconds_in;
   logic [PHASE_W:0]   phase_sum;
   logic               second_step;
   logic               ann_valid;
   logic [3:0]         ann_code;
   logic               fin;

   always_comb begin
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      hours_in    = hours_ff;
      minutes_in  = minutes_ff;
      seconds_in  = seconds_ff;
      phase_sum   = {1'b0, phase_ff} + {{PHASE_W{1'b0}}, 1'b1};
      second_step = 1'b0;
      ann_valid   = 1'b0;
      ann_code    = ANN_ONE_MINUTE;
      fin         = 1'b0;
      case (req_type)
         REQ_TICK: begin
            if (mode_ff == MODE_IDLE) begin
               hours_in   = cfg.preset_hours;
               minutes_in = cfg.preset_minutes;
               seconds_in = cfg.preset_seconds;
            end else if (mode_ff == MODE_COUNTING) begin
               second_step = phase_sum > TICKS_PER_SECOND;
               if (second_step) begin
                  phase_sum = phase_sum - TICKS_PER_SECOND;
                  // Take one second off, borrowing from minutes and hours.
                  if (seconds_ff == 6'd0) begin
                     seconds_in = LAST_MINUTE_SECOND;
                     if (minutes_ff == 6'd0) begin
                        minutes_in = LAST_MINUTE_SECOND;
                        hours_in   = hours_ff - 4'd1;
                     end else begin
                        minutes_in = minutes_ff - 6'd1;
                     end
                  end else begin
                     seconds_in = seconds_ff - 6'd1;
                  end
                  if (hours_in == 4'd0 && !voice_busy) begin
                     if (minutes_in == 6'd1 && seconds_in == 6'd0) begin
                        ann_valid = 1'b1;
                        ann_code  = ANN_ONE_MINUTE;
                     end else if (minutes_in == 6'd0) begin
                        if (seconds_in == THIRTY_SECONDS) begin
                           ann_valid = 1'b1;
                           ann_code  = ANN_THIRTY_SECONDS;
                        end else if (seconds_in != 6'd0 && seconds_in <= TEN_SECONDS) begin
                           ann_valid = 1'b1;
                           ann_code  = seconds_in[3:0] + ANN_SECONDS_OFFSET;
                        end
                     end
                  end
               end
               phase_in = phase_sum[PHASE_W-1:0];
               if (hours_in == 4'd0 && minutes_in == 6'd0 && seconds_in == 6'd0) begin
                  fin     = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
         end
         REQ_BUTTON: begin
            case (mode_ff)
               MODE_IDLE: begin
                  mode_in  = MODE_COUNTING;
                  phase_in = '0;
               end
               MODE_COUNTING: mode_in = MODE_PAUSED;
               default:       mode_in = MODE_COUNTING;
            endcase
         end
         REQ_RESET: mode_in = MODE_IDLE;
         default:   mode_in = mode_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         phase_ff   <= '0;
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
      end
   end

   always_comb begin
      rslt.mode           = mode_in;
      rslt.hours_left     = hours_in;
      rslt.minutes_left   = minutes_in;
      rslt.seconds_left   = seconds_in;
      rslt.announce_valid = ann_valid;
      rslt.announce_code  = ann_code;
      rslt.finished       = fin;
      rslt.finish_sound   = fin ? cfg.finish_voice : 3'd0;
   end

`ifndef SYNTHESIS
   // A finishing step always drops back to idle, also in the stored state.
   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && rslt.finished |=> mode_ff == MODE_IDLE)
      else $error("finish did not return the timer to idle");

   // Announcements only happen in the last hour, never on the finishing step.
   a_announce_last_hour: assert property (@(posedge clock) disable iff (reset)
      step_en && rslt.announce_valid |-> rslt.hours_left == 4'd0 && !rslt.finished)
      else $error("announcement outside the last hour or on finish");

   // While paused, nothing but a button press may move the phase.
   a_pause_freezes: assert property (@(posedge clock) disable iff (reset)
      step_en && mode_ff == MODE_PAUSED && req_type != REQ_BUTTON |=> $stable(phase_ff))
      else $error("phase moved while paused");

   // Counts only change on an accepted word.
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(seconds_ff) && $stable(minutes_ff) && $stable(hours_ff))
      else $error("count changed without a word");
`endif

endmodule

### sv/hms_countdown_timer.sv
// ============================================================================
// hms_countdown_timer
// Hours/minutes/seconds countdown timer driven by tick and button words.
// ============================================================================
// A word accepted into the input register moves on into the result register,
// which drives rsp_tvalid and rsp_tdata.
// Throughput: one word per cycle while rsp_tready is high; a stalled result
// word fills both stages and then holds req_tready low.
// Reset (synchronous, active high) clears both pipeline stages, the timer state
// (idle, zero phase and zero count) and all configuration registers.
module hms_countdown_timer (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] voice_busy, [7:1] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] mode, [5:2] hours_left,
                                    // [11:6] minutes_left, [17:12] seconds_left,
                                    // [18] announce_valid, [22:19] announce_code,
                                    // [23] finished, [26:24] finish_sound,
                                    // [31:27] zero
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);
   import hms_pkg::*;

   // Input register stage.
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_req_ff;
   logic       in_busy_ff;
   // Result register stage.
   logic       out_valid_ff, out_valid_in;
   result_type out_rslt_ff;

   cfg_type    cfg;
   result_type step_rslt;
   logic       advance;

   // A word moves from the input register into the result register whenever
   // the result register is empty or is being drained in the same cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff  <= req_tuser;
         in_busy_ff <= req_tdata[0];
      end
      if (advance) begin
         out_rslt_ff <= step_rslt;
      end
   end

   hms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The timer state advances exactly when a word is handed to the result stage.
   hms_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .req_type   (in_req_ff),
      .voice_busy (in_busy_ff),
      .cfg        (cfg),
      .rslt       (step_rslt)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_rslt_ff};

endmodule
